// ----- src/mtf_pkg.sv -----
// Shared constants and codes for the move-to-front search list.
package mtf_pkg;

    localparam int MTF_DEPTH    = 16;
    localparam int MTF_KEY_BITS = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_MTF    = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

endpackage

// ----- src/mtf_in_if.sv -----
// Command channel: action and key words with valid/ready.
interface mtf_in_if #(
    parameter int KEY_BITS = mtf_pkg::MTF_KEY_BITS
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic signed [KEY_BITS-1:0] key;

    modport source (output valid, action, key, input ready);
    modport sink   (input valid, action, key, output ready);
endinterface

// ----- src/mtf_out_if.sv -----
// Result channel: status, position and entry count words with valid/ready.
interface mtf_out_if #(
    parameter int IDX_W = $clog2(mtf_pkg::MTF_DEPTH),
    parameter int CNT_W = $clog2(mtf_pkg::MTF_DEPTH + 1)
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, status, position, entry_count, input ready);
    modport sink   (input valid, status, position, entry_count, output ready);
endinterface

// ----- src/mtf_mem.sv -----
// Key storage: one write port, one read port with registered read data.
module mtf_mem #(
    parameter int DEPTH    = mtf_pkg::MTF_DEPTH,
    parameter int KEY_BITS = mtf_pkg::MTF_KEY_BITS,
    localparam int IDX_W   = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  logic [KEY_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]    i_raddr,
    output logic [KEY_BITS-1:0] o_rdata
);

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mtf_seq.sv -----
// Sequencer: streams the list through one equality comparator and moves entries.
module mtf_seq #(
    parameter int DEPTH    = mtf_pkg::MTF_DEPTH,
    parameter int KEY_BITS = mtf_pkg::MTF_KEY_BITS,
    localparam int IDX_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command
    input  logic                i_valid,
    input  logic [1:0]          i_action,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_ready,
    // result
    input  logic                i_out_free,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [IDX_W-1:0]    o_position,
    output logic [CNT_W-1:0]    o_count,
    // memory
    input  logic [KEY_BITS-1:0] i_rdata,
    output logic [IDX_W-1:0]    o_raddr,
    output logic                o_we,
    output logic [IDX_W-1:0]    o_waddr,
    output logic [KEY_BITS-1:0] o_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_UP   = 6'b000100,
        ST_WR0  = 6'b001000,
        ST_DN   = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state              r_state,  n_state;
    mtf_pkg::t_action    r_action, n_action;
    mtf_pkg::t_status    r_status, n_status;
    logic [KEY_BITS-1:0] r_key,    n_key;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic [IDX_W-1:0]    r_pos,    n_pos;
    logic [CNT_W-1:0]    r_count,  n_count;

    logic [IDX_W-1:0] l_last_idx;
    logic             l_at_last;
    logic             l_hit;

    assign l_last_idx = IDX_W'(r_count - CNT_W'(1));
    assign l_at_last  = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign l_hit      = (i_rdata == r_key);

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_status = r_status;
        n_key    = r_key;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        o_raddr  = r_idx;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = r_key;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_action = mtf_pkg::t_action'(i_action);
                    n_key    = i_key;
                    n_pos    = '0;
                    n_status = mtf_pkg::STS_OK;
                    if (mtf_pkg::t_action'(i_action) == mtf_pkg::ACT_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = mtf_pkg::STS_FULL;
                            n_state  = ST_FIN;
                        end else if (r_count == '0) begin
                            n_state = ST_WR0;
                        end else begin
                            // open slot 0: copy back to front, last entry first
                            n_idx   = l_last_idx;
                            o_raddr = l_last_idx;
                            n_state = ST_UP;
                        end
                    end else if (r_count == '0) begin
                        n_status = mtf_pkg::STS_NOT_FOUND;
                        n_state  = ST_FIN;
                    end else begin
                        n_idx   = '0;
                        o_raddr = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read data holds entry r_idx; the next address is issued here if the scan goes on
                if (l_hit) begin
                    n_pos = r_idx;
                    case (r_action)
                        mtf_pkg::ACT_MTF: begin
                            if (r_idx == '0) begin
                                n_state = ST_FIN;
                            end else begin
                                n_idx   = r_idx - IDX_W'(1);
                                o_raddr = r_idx - IDX_W'(1);
                                n_state = ST_UP;
                            end
                        end
                        mtf_pkg::ACT_DELETE: begin
                            if (l_at_last) begin
                                n_count = r_count - CNT_W'(1);
                                n_state = ST_FIN;
                            end else begin
                                n_idx   = r_idx + IDX_W'(1);
                                o_raddr = r_idx + IDX_W'(1);
                                n_state = ST_DN;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end else if (l_at_last) begin
                    n_status = mtf_pkg::STS_NOT_FOUND;
                    n_state  = ST_FIN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    o_raddr = r_idx + IDX_W'(1);
                end
            end
            ST_UP: begin
                o_we    = 1'b1;
                o_waddr = r_idx + IDX_W'(1);
                o_wdata = i_rdata;
                if (r_idx == '0) begin
                    n_state = ST_WR0;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    o_raddr = r_idx - IDX_W'(1);
                end
            end
            ST_WR0: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_key;
                if (r_action == mtf_pkg::ACT_INSERT) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_FIN;
            end
            ST_DN: begin
                o_we    = 1'b1;
                o_waddr = r_idx - IDX_W'(1);
                o_wdata = i_rdata;
                if (l_at_last) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    o_raddr = r_idx + IDX_W'(1);
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_status <= n_status;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_done     = (r_state == ST_FIN);
    assign o_status   = r_status;
    assign o_position = r_pos;
    assign o_count    = r_count;

endmodule

// ----- src/move_to_front_search_list_unit.sv -----
// Top level of the move-to-front search list.
//
// Holds an ordered list of up to DEPTH keys of KEY_BITS bits, front to back,
// in a single-port-write, single-port-read memory. Each command word does
// one of: insert at front (duplicates allowed; dropped with status full when
// the list holds DEPTH keys), search, search and move the match to the
// front, or delete the first match. Exactly one result word comes back per
// command, giving status, the match position counted from the front before
// any move, and the key count afterwards. One command is in flight at a
// time: the input is not ready from acceptance until the result is loaded
// into the output register. Cost is set by the single memory port and the
// one equality comparator: a search walks the list one entry per cycle, and
// each entry moved by insert, move-to-front or delete adds one more step.
// A stalled result word holds the sequencer in its finish state. No
// clearing pass is needed after reset; entries beyond the count are never
// read for a result.
module move_to_front_search_list_unit #(
    parameter int DEPTH    = mtf_pkg::MTF_DEPTH,
    parameter int KEY_BITS = mtf_pkg::MTF_KEY_BITS,
    localparam int IDX_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mtf_in_if.sink   i_in,
    mtf_out_if.source o_out
);

    // sequencer <-> memory
    logic [IDX_W-1:0]    w_raddr;
    logic [IDX_W-1:0]    w_waddr;
    logic                w_we;
    logic [KEY_BITS-1:0] w_wdata;
    logic [KEY_BITS-1:0] w_rdata;

    // sequencer result
    logic             w_done;
    logic [1:0]       w_status;
    logic [IDX_W-1:0] w_position;
    logic [CNT_W-1:0] w_count;
    logic             w_out_free;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [IDX_W-1:0] r_out_position;
    logic [CNT_W-1:0] r_out_count;

    // output slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_out.ready;

    mtf_seq #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_action   (i_in.action),
        .i_key      (i_in.key),
        .o_ready    (i_in.ready),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_status   (w_status),
        .o_position (w_position),
        .o_count    (w_count),
        .i_rdata    (w_rdata),
        .o_raddr    (w_raddr),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata)
    );

    mtf_mem #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result word register; loaded as the sequencer leaves its finish state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_out_status   <= w_status;
            r_out_position <= w_position;
            r_out_count    <= w_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.position    = r_out_position;
    assign o_out.entry_count = r_out_count;

    // one command at a time: ready is low in the cycle after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("command accepted while another is in flight");

    // key count never exceeds the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    // a dropped insert only happens on a full list and reports position zero
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == mtf_pkg::STS_FULL)
        |-> (o_out.entry_count == CNT_W'(DEPTH)) && (o_out.position == '0))
        else $error("full status with non-full list or nonzero position");

    // a miss reports position zero
    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == mtf_pkg::STS_NOT_FOUND) |-> (o_out.position == '0))
        else $error("miss with nonzero position");

endmodule

// ----- bench/tb_move_to_front_search_list_unit.sv -----
// Self-checking bench for the move-to-front search list: random commands, shadow list, checks.
`timescale 1ns / 1ps

module tb_move_to_front_search_list_unit;

    // Generous cap on the whole run, covering the slowest commands plus
    // sender gaps and receiver stalls; ~1700 words stay far below this.
    localparam int CYCLE_LIMIT = 1000000;
    // Cycles to watch for stray result words after the last expected one.
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int REPORT_CAP = 100;

    typedef struct {
        mtf_pkg::t_action     action;
        logic signed [31:0]   key;
    } t_cmd_word;

    typedef struct {
        mtf_pkg::t_status status;
        logic [3:0]       position;
        logic [4:0]       entry_count;
    } t_result_word;

    // Ordered key list, front at index 0.
    typedef struct {
        logic [31:0] keys [mtf_pkg::MTF_DEPTH];
        int          count;
    } t_key_list;

    logic i_clk;
    logic i_rst_n;

    mtf_in_if  cmd_if ();
    mtf_out_if res_if ();

    move_to_front_search_list_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Command words not yet presented, and result words still owed by the block.
    t_cmd_word    pending_cmds [$];
    t_result_word owed_results [$];

    t_key_list gen_list;    // list as the stimulus generator sees it
    t_key_list dut_list;    // list as the block should hold it, per accepted word

    int  send_idle_pct;
    int  recv_stall_pct;
    int  fail_count;
    int  cycle_count;
    logic cmd_taken;        // command word accepted at the last rising edge

    // Applies one command to a list and returns the result word it produces.
    // Only the first equal key from the front counts; misses and full
    // inserts leave the list alone.
    function automatic t_result_word list_apply(inout t_key_list lst, input t_cmd_word cmd);
        t_result_word r;
        int hit;
        int i;
        r.status   = mtf_pkg::STS_OK;
        r.position = '0;
        if (cmd.action == mtf_pkg::ACT_INSERT) begin
            if (lst.count >= mtf_pkg::MTF_DEPTH) begin
                r.status = mtf_pkg::STS_FULL;
            end else begin
                for (i = lst.count; i > 0; i--) lst.keys[i] = lst.keys[i-1];
                lst.keys[0] = cmd.key;
                lst.count++;
            end
        end else begin
            hit = lst.count;
            for (i = lst.count - 1; i >= 0; i--)
                if (lst.keys[i] == cmd.key) hit = i;
            if (hit >= lst.count) begin
                r.status = mtf_pkg::STS_NOT_FOUND;
            end else begin
                r.position = hit[3:0];
                if (cmd.action == mtf_pkg::ACT_MTF) begin
                    for (i = hit; i > 0; i--) lst.keys[i] = lst.keys[i-1];
                    lst.keys[0] = cmd.key;
                end else if (cmd.action == mtf_pkg::ACT_DELETE) begin
                    for (i = hit; i + 1 < lst.count; i++) lst.keys[i] = lst.keys[i+1];
                    lst.count--;
                end
            end
        end
        r.entry_count = lst.count[4:0];
        return r;
    endfunction

    // Queues a command and tracks its effect so later keys can aim at hits.
    task automatic queue_cmd(input mtf_pkg::t_action act, input logic [31:0] key);
        t_cmd_word    cmd;
        t_result_word unused;
        cmd.action = act;
        cmd.key    = key;
        unused = list_apply(gen_list, cmd);
        pending_cmds.push_back(cmd);
    endtask

    // Mostly keys already held (hits, duplicates), then a small pool that
    // collides often, then full-range values for bit coverage.
    function automatic logic [31:0] pick_key(input t_key_list lst);
        int unsigned roll;
        logic [31:0] k;
        roll = $urandom_range(99);
        if (lst.count > 0 && roll < 55) begin
            k = lst.keys[$urandom_range(lst.count - 1)];
        end else if (roll < 80) begin
            k = $urandom_range(7);
            if ($urandom_range(1) == 1) k = ~k;
        end else begin
            k = $urandom();
        end
        return k;
    endfunction

    // Random commands in segments with differing insert rates, so the list
    // swings between empty and full and full inserts get exercised.
    task automatic queue_random(input int n);
        int ins_pct;
        int roll;
        mtf_pkg::t_action act;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(2))
                    0: ins_pct = 10;
                    1: ins_pct = 35;
                    default: ins_pct = 70;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < ins_pct) act = mtf_pkg::ACT_INSERT;
            else begin
                case ($urandom_range(2))
                    0: act = mtf_pkg::ACT_SEARCH;
                    1: act = mtf_pkg::ACT_MTF;
                    default: act = mtf_pkg::ACT_DELETE;
                endcase
            end
            queue_cmd(act, pick_key(gen_list));
        end
    endtask

    // Waits until every queued word went in and every result came back.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_if.valid || owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Driver: changes inputs on the falling edge. A presented word is held
    // until the edge that accepts it; the next one may follow at once.
    always @(negedge i_clk) begin
        t_cmd_word nxt;
        logic      next_valid;
        logic      hold;
        next_valid = 1'b0;
        nxt.action = mtf_pkg::ACT_INSERT;
        nxt.key    = '0;
        if (i_rst_n) begin
            hold = cmd_if.valid && !cmd_taken;
            if (hold) begin
                next_valid = 1'b1;
                nxt.action = mtf_pkg::t_action'(cmd_if.action);
                nxt.key    = cmd_if.key;
            end else if (pending_cmds.size() != 0
                         && $urandom_range(99) >= send_idle_pct) begin
                next_valid = 1'b1;
                nxt = pending_cmds.pop_front();
            end
        end
        cmd_if.valid  <= next_valid;
        cmd_if.action <= nxt.action;
        cmd_if.key    <= nxt.key;
        res_if.ready  <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: samples both channels on the rising edge. Each accepted
    // command is run through the shadow list; each result word is checked
    // against the oldest owed one.
    always @(posedge i_clk) begin
        t_cmd_word    got_cmd;
        t_result_word want;
        cmd_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                got_cmd.action = mtf_pkg::t_action'(cmd_if.action);
                got_cmd.key    = cmd_if.key;
                owed_results.push_back(list_apply(dut_list, got_cmd));
            end
            if (res_if.valid && res_if.ready) begin
                if (owed_results.size() == 0) begin
                    if (fail_count < REPORT_CAP)
                        $display("%0t: result word with none expected: %s=%0d %s=%0d %s=%0d",
                                 $time, "status", res_if.status, "position",
                                 res_if.position, "count", res_if.entry_count);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, res_if.status);
                    check_field("position", want.position, res_if.position);
                    check_field("entry_count", want.entry_count, res_if.entry_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_move_to_front_search_list_unit: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.action  = mtf_pkg::ACT_INSERT;
        cmd_if.key     = '0;
        res_if.ready   = 1'b0;
        cmd_taken      = 1'b0;
        cycle_count    = 0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_list.count = 0;
        dut_list.count = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: misses on an empty list.
        queue_cmd(mtf_pkg::ACT_SEARCH, 32'h0000_0000);
        queue_cmd(mtf_pkg::ACT_DELETE, 32'h0000_0000);
        queue_cmd(mtf_pkg::ACT_MTF, 32'hFFFF_FFFF);
        // Key extremes, with a duplicate of the largest.
        queue_cmd(mtf_pkg::ACT_INSERT, 32'h8000_0000);
        queue_cmd(mtf_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        queue_cmd(mtf_pkg::ACT_INSERT, 32'h0000_0000);
        queue_cmd(mtf_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        queue_cmd(mtf_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        queue_cmd(mtf_pkg::ACT_SEARCH, 32'h8000_0000);   // at the back
        queue_cmd(mtf_pkg::ACT_SEARCH, 32'h7FFF_FFFF);   // first of two copies
        queue_cmd(mtf_pkg::ACT_MTF, 32'h0000_0000);      // moves from the middle
        queue_cmd(mtf_pkg::ACT_MTF, 32'h0000_0000);      // already at the front
        queue_cmd(mtf_pkg::ACT_SEARCH, 32'h1234_5678);   // miss on a non-empty list
        queue_cmd(mtf_pkg::ACT_DELETE, 32'h7FFF_FFFF);   // first copy only
        queue_cmd(mtf_pkg::ACT_DELETE, 32'h8000_0000);   // from the back
        queue_cmd(mtf_pkg::ACT_DELETE, 32'h0000_0000);   // from the front
        // Fill up, overflow, then work the last slot.
        for (int i = 0; i < mtf_pkg::MTF_DEPTH - 2; i++)
            queue_cmd(mtf_pkg::ACT_INSERT, 32'h5555_5555 ^ i);
        queue_cmd(mtf_pkg::ACT_INSERT, 32'hAAAA_AAAA);   // dropped, list full
        queue_cmd(mtf_pkg::ACT_MTF, 32'h7FFF_FFFF);      // match at the last position
        queue_cmd(mtf_pkg::ACT_DELETE, 32'hFFFF_FFFF);   // now at the last position
        queue_cmd(mtf_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        send_idle_pct = 52;
        recv_stall_pct = 0;
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        send_idle_pct = 0;
        recv_stall_pct = 52;
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        send_idle_pct = 23;
        recv_stall_pct = 23;
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        // Any stray result word shows up in the monitor during this window.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("tb_move_to_front_search_list_unit: PASS");
        end else begin
            $display("tb_move_to_front_search_list_unit: FAIL");
        end
        $finish;
    end

endmodule
